[design/hcl_pkg.sv]
package hcl_pkg;

	localparam int unsigned LINE_LEN = 12;

	localparam logic [2:0] VERDICT_NONE    = 3'd0;
	localparam logic [2:0] VERDICT_LIGHT   = 3'd1;
	localparam logic [2:0] VERDICT_RAINBOW = 3'd2;
	localparam logic [2:0] VERDICT_WRONG   = 3'd3;
	localparam logic [2:0] VERDICT_FRAME   = 3'd4;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_D     = 8'h44;
	localparam logic [7:0] CHAR_SIX   = 8'h36;
	localparam logic [7:0] CHAR_EIGHT = 8'h38;

	localparam logic [7:0] WHEEL_THIRD     = 8'd85;
	localparam logic [7:0] WHEEL_TWO_THIRD = 8'd170;
	localparam logic [7:0] WHEEL_FULL      = 8'd255;

	// index 0 holds the first character of the line
	localparam logic [LINE_LEN-1:0][7:0] RAINBOW_WORD =
		{"W", "O", "B", "N", "I", "A", "R", "L", "L", "U", "F", "#"};

	typedef logic [LINE_LEN-1:0][7:0] hcl_line_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] character;
	} hcl_req_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic       refresh;
		logic [7:0] led6_red;
		logic [7:0] led6_green;
		logic [7:0] led6_blue;
		logic [7:0] led7_red;
		logic [7:0] led7_green;
		logic [7:0] led7_blue;
		logic [7:0] led8_red;
		logic [7:0] led8_green;
		logic [7:0] led8_blue;
	} hcl_res_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [1:0]  led;
		logic [23:0] color;
	} hcl_eval_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c >= "A") begin
			v = c - 8'd55;
		end else begin
			v = c - "0";
		end
		return v[3:0];
	endfunction

	function automatic logic [23:0] wheel_color(input logic [7:0] pos);
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t3;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		p = WHEEL_FULL - pos;
		if (p < WHEEL_THIRD) begin
			q = p;
		end else if (p < WHEEL_TWO_THIRD) begin
			q = p - WHEEL_THIRD;
		end else begin
			q = p - WHEEL_TWO_THIRD;
		end
		t3 = 8'(q * 8'd3);
		if (p < WHEEL_THIRD) begin
			r = WHEEL_FULL - t3;
			g = 8'd0;
			b = t3;
		end else if (p < WHEEL_TWO_THIRD) begin
			r = 8'd0;
			g = t3;
			b = WHEEL_FULL - t3;
		end else begin
			r = t3;
			g = WHEEL_FULL - t3;
			b = 8'd0;
		end
		return {r, g, b};
	endfunction

endpackage

[design/hex_color_command_led_controller.sv]
// hex color command led controller
// request channel (req_valid, req_ready, req): one received character
// (operation 0) or one timer tick (operation 1) per request.
// result channel (res_valid, res_ready, res): exactly one result per
// request, in request order.
// characters are collected into a line of up to 12; CR or LF, or the
// 12th character, evaluates it: "#RRGGBBDn" sets LED n (6..8),
// "#FULLRAINBOW" starts rainbow mode, anything else is wrong format.
// ticks advance the wheel position and, in rainbow mode, send a frame.
// path: a request passes the input register, then evaluation into the
// result register.
// throughput: one request per cycle while the receiver takes every result.
// reset: line empties, colors go black, rainbow off, position zero;
// no result pending.
// when the receiver stalls, the result register holds and the input
// register takes one more request if it is empty; after that req_ready drops.
module hex_color_command_led_controller
	import hcl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  hcl_req_t req,
	output logic     res_valid,
	input  logic     res_ready,
	output hcl_res_t res
);

	logic                     valid_s1;
	hcl_req_t                 req_s1;
	logic                     res_valid_q;
	hcl_res_t                 res_q;
	hcl_line_t                line_q;
	logic [3:0]               count_q;
	logic [2:0][23:0]         color_q;
	logic                     rainbow_q;
	logic [7:0]               wheel_q;

	logic                     advance;
	logic                     fire;
	logic                     is_eol;
	logic [3:0]               wr_idx;
	logic [3:0]               count_inc;
	logic                     do_eval;
	hcl_line_t                line_view;
	logic [3:0]               eval_count;
	hcl_eval_t                eval;
	logic [2:0][23:0]         color_next;
	logic [23:0]              frame;
	hcl_res_t                 res_next;

	assign advance   = !res_valid_q || res_ready;
	assign req_ready = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;

	assign is_eol    = req_s1.character == CHAR_CR || req_s1.character == CHAR_LF;
	assign wr_idx    = (count_q >= 4'(LINE_LEN)) ? 4'd0 : count_q;
	assign count_inc = wr_idx + 4'd1;
	assign do_eval   = !req_s1.operation && (is_eol || count_inc == 4'(LINE_LEN));
	assign eval_count = is_eol ? count_q : count_inc;

	always_comb begin
		for (int i = 0; i < LINE_LEN; i++) begin
			line_view[i] = (!is_eol && wr_idx == 4'(i)) ? req_s1.character : line_q[i];
		end
	end

	hcl_line_eval u_eval (
		.line   (line_view),
		.count  (eval_count),
		.result (eval)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			color_next[i] = (eval.led == 2'(i)) ? eval.color : color_q[i];
		end
	end

	assign frame = wheel_color(wheel_q);

	always_comb begin
		res_next = '0;
		if (req_s1.operation) begin
			if (rainbow_q) begin
				res_next.verdict    = VERDICT_FRAME;
				res_next.refresh    = 1'b1;
				{res_next.led6_red, res_next.led6_green, res_next.led6_blue} = frame;
				{res_next.led7_red, res_next.led7_green, res_next.led7_blue} = frame;
				{res_next.led8_red, res_next.led8_green, res_next.led8_blue} = frame;
			end
		end else if (do_eval) begin
			res_next.verdict = eval.verdict;
			if (eval.verdict == VERDICT_LIGHT) begin
				res_next.refresh = 1'b1;
				{res_next.led6_red, res_next.led6_green, res_next.led6_blue} =
					color_next[0];
				{res_next.led7_red, res_next.led7_green, res_next.led7_blue} =
					color_next[1];
				{res_next.led8_red, res_next.led8_green, res_next.led8_blue} =
					color_next[2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			count_q     <= '0;
			color_q     <= '0;
			rainbow_q   <= 1'b0;
			wheel_q     <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (fire) begin
				if (req_s1.operation) begin
					wheel_q <= wheel_q + 8'd1;
				end else begin
					count_q <= do_eval ? 4'd0 : count_inc;
					if (do_eval && eval.verdict == VERDICT_LIGHT) begin
						color_q   <= color_next;
						rainbow_q <= 1'b0;
					end
					if (do_eval && eval.verdict == VERDICT_RAINBOW) begin
						rainbow_q <= 1'b1;
						wheel_q   <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (fire) begin
			res_q <= res_next;
			if (!req_s1.operation && !is_eol) begin
				for (int i = 0; i < LINE_LEN; i++) begin
					if (wr_idx == 4'(i)) begin
						line_q[i] <= req_s1.character;
					end
				end
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[design/hcl_line_eval.sv]
module hcl_line_eval
	import hcl_pkg::*;
(
	input  hcl_line_t  line,
	input  logic [3:0] count,
	output hcl_eval_t  result
);

	logic       hex_ok;
	logic [7:0] led_char;

	always_comb begin
		hex_ok = 1'b1;
		for (int i = 1; i < 7; i++) begin
			hex_ok = hex_ok & is_hex(line[i]);
		end
	end

	assign led_char = line[8] - CHAR_SIX;

	always_comb begin
		result.verdict = VERDICT_WRONG;
		result.led     = led_char[1:0];
		result.color   = {hex_nibble(line[1]), hex_nibble(line[2]),
			hex_nibble(line[3]), hex_nibble(line[4]),
			hex_nibble(line[5]), hex_nibble(line[6])};
		if (count == 4'd9) begin
			if (line[0] == CHAR_HASH && hex_ok && line[7] == CHAR_D &&
					line[8] >= CHAR_SIX && line[8] <= CHAR_EIGHT) begin
				result.verdict = VERDICT_LIGHT;
			end
		end else if (count == 4'(LINE_LEN)) begin
			if (line == RAINBOW_WORD) begin
				result.verdict = VERDICT_RAINBOW;
			end
		end
	end

endmodule

[design/hcl_checker.sv]
module hcl_checker
	import hcl_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_ready,
	input logic     res_valid,
	input logic     res_ready,
	input hcl_res_t res
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.verdict <= VERDICT_FRAME)
		else $error("verdict out of range");

	a_refresh_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.refresh ==
			(res.verdict == VERDICT_LIGHT || res.verdict == VERDICT_FRAME))
		else $error("refresh does not match verdict");

	a_dark_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.refresh |->
			res.led6_red == 8'd0 && res.led6_green == 8'd0 && res.led6_blue == 8'd0 &&
			res.led7_red == 8'd0 && res.led7_green == 8'd0 && res.led7_blue == 8'd0 &&
			res.led8_red == 8'd0 && res.led8_green == 8'd0 && res.led8_blue == 8'd0)
		else $error("color fields set without refresh");

	// room for a request whenever the result side is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> req_ready)
		else $error("request blocked with empty result register");

endmodule

bind hex_color_command_led_controller hcl_checker u_hcl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
